### src/fct_pkg.sv
// fct_pkg: operation codes, field widths and fixed-point constants for the frustum culler
// no dependencies; imported by frustum_culling_test
`default_nettype none

package fct_pkg;

    localparam int unsigned VEC_W   = 32;   // q16.16 signed vector and scalar fields
    localparam int unsigned HALF_W  = 31;   // q15.16 unsigned half extents
    localparam int unsigned FRAC_W  = 16;   // fraction bits of the q16.16 inputs
    localparam int unsigned MOP_W   = VEC_W + 1;         // multiplier operand, holds |n| = 2^31
    localparam int unsigned PROD_W  = 2 * MOP_W;         // exact q34.32 product
    localparam int unsigned ACC_W   = PROD_W + 2;        // six products plus offset and radius
    localparam int unsigned TERM_W  = 3;                 // up to six products per plane
    localparam int unsigned COMPS   = 3;                 // x, y, z

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic        [HALF_W-1:0] t_half;
    typedef logic signed [ACC_W-1:0]  t_acc;

endpackage

`default_nettype wire

### src/frustum_culling_test.sv
// frustum_culling_test: sphere and box culling against stored planes, one shared multiplier
// depends on fct_pkg
`default_nettype none

//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_operation, i_plane_index, i_vec_*, i_scalar,
//                                            i_half_*
//  result    out        o_valid / i_ready    o_visible, o_reject_plane
//
//  a plane load or an unused code gives no result
//  a test runs plane by plane: per plane an init step, then T = 3 products for a sphere
//  and 6 for a box, each formed in the one 33x33 multiplier and added into the accumulator
//  behind it, then a sign check; a final step hands the result to the output register
//  o_ready is high only while the sequencer is idle; a waiting result does not block it
//  reset clears the sequencer and the output valid; plane storage is not cleared

module frustum_culling_test
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = 6
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [1:0]              i_operation,
    input  wire  [2:0]              i_plane_index,
    input  wire  signed [VEC_W-1:0] i_vec_x,
    input  wire  signed [VEC_W-1:0] i_vec_y,
    input  wire  signed [VEC_W-1:0] i_vec_z,
    input  wire  signed [VEC_W-1:0] i_scalar,
    input  wire  [HALF_W-1:0]       i_half_x,
    input  wire  [HALF_W-1:0]       i_half_y,
    input  wire  [HALF_W-1:0]       i_half_z,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic                    o_visible,
    output logic [2:0]              o_reject_plane
);

    // plane index width, at least one bit
    localparam int IW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [IW-1:0] LAST_PLANE = IW'(NUM_PLANES - 1);
    localparam logic [3:0]    NUM_PL4    = 4'(NUM_PLANES);
    localparam logic [2:0]    VIS_CODE   = 3'(NUM_PLANES);
    localparam logic [TERM_W-1:0] LAST_SPH = TERM_W'(COMPS - 1);
    localparam logic [TERM_W-1:0] LAST_BOX = TERM_W'(2 * COMPS - 1);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,   // load accumulator with offset (and radius)
        S_MUL   = 6'b000100,   // one product into the product register
        S_ADD   = 6'b001000,   // fold product into the accumulator
        S_CHECK = 6'b010000,   // sign test for the current plane
        S_DONE  = 6'b100000    // hand result to the output register
    } t_state;

    // plane storage, written by loads, read at the current plane
    t_vec r_nx  [NUM_PLANES];
    t_vec r_ny  [NUM_PLANES];
    t_vec r_nz  [NUM_PLANES];
    t_vec r_off [NUM_PLANES];

    t_state             r_state, n_state;
    logic               r_box;          // box test rather than sphere
    t_vec               r_cx, r_cy, r_cz, r_rad;
    t_half              r_hx, r_hy, r_hz;
    logic [IW-1:0]      r_plane;
    logic [TERM_W-1:0]  r_term;
    logic signed [PROD_W-1:0] r_prod;
    t_acc               r_acc;
    logic               r_res_vis;
    logic [2:0]         r_res_plane;
    logic               r_out_valid;
    logic               r_visible;
    logic [2:0]         r_reject;

    logic               accept;
    logic [1:0]         comp;
    t_vec               cur_n;
    logic signed [MOP_W-1:0] mop_a, mop_b;
    logic signed [PROD_W-1:0] prod;
    t_acc               acc_init;
    logic               last_term;
    logic               out_free;

    assign o_ready        = (r_state == S_IDLE);
    assign accept         = i_valid && o_ready;
    assign o_valid        = r_out_valid;
    assign o_visible      = r_visible;
    assign o_reject_plane = r_reject;
    assign out_free       = !r_out_valid || i_ready;

    // component of the current term: x, y, z, then again x, y, z for box reach
    always_comb begin
        if (r_term >= TERM_W'(COMPS)) begin
            comp = 2'(r_term - TERM_W'(COMPS));
        end else begin
            comp = 2'(r_term);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (comp)
            2'd0:    cur_n = r_nx[r_plane];
            2'd1:    cur_n = r_ny[r_plane];
            default: cur_n = r_nz[r_plane];
        endcase
        if (r_term < TERM_W'(COMPS)) begin
            // distance term: normal times centre
            mop_a = MOP_W'(cur_n);
            unique case (comp)
                2'd0:    mop_b = MOP_W'(r_cx);
                2'd1:    mop_b = MOP_W'(r_cy);
                default: mop_b = MOP_W'(r_cz);
            endcase
        end else begin
            // reach term: |normal| times half extent, both non-negative
            mop_a = cur_n[VEC_W-1] ? -MOP_W'(cur_n) : MOP_W'(cur_n);
            unique case (comp)
                2'd0:    mop_b = $signed({2'b00, r_hx});
                2'd1:    mop_b = $signed({2'b00, r_hy});
                default: mop_b = $signed({2'b00, r_hz});
            endcase
        end
    end

    assign prod = mop_a * mop_b;

    // offset, and the radius for a sphere, raised to q36.32
    always_comb begin
        acc_init = ACC_W'(r_off[r_plane]) <<< FRAC_W;
        if (!r_box) begin
            acc_init = acc_init + (ACC_W'(r_rad) <<< FRAC_W);
        end
    end

    assign last_term = r_box ? (r_term == LAST_BOX) : (r_term == LAST_SPH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_op'(i_operation) == OP_SPHERE ||
                               t_op'(i_operation) == OP_BOX)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT:  n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = last_term ? S_CHECK : S_MUL;
            S_CHECK: begin
                if (r_acc[ACC_W-1] || r_plane == LAST_PLANE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (t_op'(i_operation) == OP_LOAD && {1'b0, i_plane_index} < NUM_PL4) begin
                r_nx[i_plane_index[IW-1:0]]  <= i_vec_x;
                r_ny[i_plane_index[IW-1:0]]  <= i_vec_y;
                r_nz[i_plane_index[IW-1:0]]  <= i_vec_z;
                r_off[i_plane_index[IW-1:0]] <= i_scalar;
            end
            r_box   <= (t_op'(i_operation) == OP_BOX);
            r_cx    <= i_vec_x;
            r_cy    <= i_vec_y;
            r_cz    <= i_vec_z;
            r_rad   <= i_scalar;
            r_hx    <= i_half_x;
            r_hy    <= i_half_y;
            r_hz    <= i_half_z;
            r_plane <= '0;
        end
        unique case (r_state)
            S_INIT: begin
                r_acc  <= acc_init;
                r_term <= '0;
            end
            S_MUL: begin
                r_prod <= prod;
            end
            S_ADD: begin
                r_acc  <= r_acc + ACC_W'(r_prod);
                r_term <= r_term + 1'b1;
            end
            S_CHECK: begin
                // touching the plane exactly counts as inside
                if (r_acc[ACC_W-1]) begin
                    r_res_vis   <= 1'b0;
                    r_res_plane <= 3'(r_plane);
                end else begin
                    r_res_vis   <= 1'b1;
                    r_res_plane <= VIS_CODE;
                    if (r_plane != LAST_PLANE) begin
                        r_plane <= r_plane + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_visible <= r_res_vis;
                    r_reject  <= r_res_plane;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
